[sv/u8san_pkg.sv]
package u8san_pkg;

   // Output queue sizing: one step can produce up to four bytes
   localparam int MaxResults = 4;
   localparam int QueueDepth = 8;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Replacement byte for anything malformed
   localparam logic [7:0] QMark = 8'h3F;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } q_entry_type;

   // Total sequence length announced by a lead byte, 0 if not a lead
   function automatic logic [2:0] seq_len(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd0;
      if ((c & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((c & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((c & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Continuation byte: 10xxxxxx
   function automatic logic is_cont(input logic [7:0] c);
      return (c & 8'hC0) == 8'h80;
   endfunction

endpackage

[sv/utf8_sequence_sanitizer.sv]
// Channel | Dir | Ports                      | tdata fields (low bit up) | tlast
// req     | in  | req_tvalid/tready/tdata/.. | data_byte[7:0]            | end_of_text
// rsp     | out | rsp_tvalid/tready/tdata/.. | clean_byte[7:0]           | final_byte
//
// One input word is accepted per cycle while req_tready is high; its 0 to 4
// result words are decided in the same cycle and pushed into an 8-entry output
// queue. Results leave the queue one word per cycle while rsp_tready is high.
// req_tready is high while the queue holds at most 4 words, so a stalled
// output side backs up into the input only once that room is gone.
// Synchronous reset empties the queue and the look-ahead window.
module utf8_sequence_sanitizer
   import u8san_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] clean_byte
   output logic       rsp_tlast    // final_byte
);

   // look-ahead window and terminator flag
   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];
   logic [1:0]  pcnt_ff, pcnt_in;
   logic        term_ff, term_in;

   // output queue, head at entry 0
   q_entry_type             q_ff    [QueueDepth];
   q_entry_type             q_in    [QueueDepth];
   q_entry_type             q_shift [QueueDepth];
   logic [QueueCntW-1:0]    count_ff, count_in;

   // per-step result lanes
   q_entry_type lane [MaxResults];
   logic [1:0]  flush_n;
   logic        flush_pass;
   logic        tail_en;
   logic [7:0]  tail_byte;
   logic        do_fresh;
   logic [2:0]  n_new;
   logic [2:0]  need;

   logic        push, pop;
   logic [7:0]  b;
   logic        eot;

   assign b   = req_tdata;
   assign eot = req_tlast;

   assign req_tready = (count_ff <= QueueCntW'(QueueDepth - MaxResults));
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = q_ff[0].data;
   assign rsp_tlast  = q_ff[0].last;

   assign need = seq_len(pend_ff[0]);

   // decide the step: a flushed prefix (window bytes or '?') and an optional tail
   always_comb begin
      flush_n    = 2'd0;
      flush_pass = 1'b0;
      tail_en    = 1'b0;
      tail_byte  = b;
      do_fresh   = 1'b0;
      pend_in    = pend_ff;
      pcnt_in    = pcnt_ff;
      term_in    = term_ff;

      if (term_ff) begin
         tail_en = 1'b1;
      end else if (pcnt_ff != 2'd0) begin
         if (is_cont(b)) begin
            if ({1'b0, pcnt_ff} + 3'd1 == need) begin
               // sequence complete: release it unchanged
               flush_n    = pcnt_ff;
               flush_pass = 1'b1;
               tail_en    = 1'b1;
               pcnt_in    = 2'd0;
            end else if (eot) begin
               // cut off by the end of the buffer
               flush_n   = pcnt_ff;
               tail_en   = 1'b1;
               tail_byte = QMark;
               pcnt_in   = 2'd0;
            end else begin
               case (pcnt_ff)
                  2'd1:    pend_in[1] = b;
                  2'd2:    pend_in[2] = b;
                  default: ;
               endcase
               pcnt_in = pcnt_ff + 2'd1;
            end
         end else begin
            // broken sequence: flush as errors, then judge this byte afresh
            flush_n  = pcnt_ff;
            pcnt_in  = 2'd0;
            do_fresh = 1'b1;
         end
      end else begin
         do_fresh = 1'b1;
      end

      // byte at the start of a possible sequence
      if (do_fresh) begin
         if (b == 8'h00) begin
            term_in = 1'b1;
            tail_en = 1'b1;
         end else if (b < 8'h80) begin
            tail_en = 1'b1;
         end else if (seq_len(b) != 3'd0 && !eot) begin
            pend_in[0] = b;
            pcnt_in    = 2'd1;
         end else begin
            tail_en   = 1'b1;
            tail_byte = QMark;
         end
      end

      if (eot) begin
         pcnt_in = 2'd0;
         term_in = 1'b0;
      end
   end

   assign n_new = {1'b0, flush_n} + {2'b0, tail_en};

   // result lanes in output order; final_byte on the last one of an end step
   always_comb begin
      for (int k = 0; k < MaxResults; k++) begin
         lane[k].data = tail_byte;
         if (k < 3) begin
            if (2'(k) < flush_n) begin
               lane[k].data = flush_pass ? pend_ff[k] : QMark;
            end
         end
         lane[k].last = eot && (3'(k) + 3'd1 == n_new);
      end
   end

   // queue: shift out at the head, append new lanes behind the survivors
   always_comb begin
      logic [QueueCntW-1:0] base;
      logic [QueueCntW-1:0] off;
      base = count_ff - QueueCntW'(pop);
      for (int i = 0; i < QueueDepth; i++) begin
         q_shift[i] = q_ff[(i + 1) % QueueDepth];
      end
      for (int i = 0; i < QueueDepth; i++) begin
         q_in[i] = q_ff[i];
         off     = QueueCntW'(i) - base;
         if (QueueCntW'(i) < base) begin
            if (pop) begin
               q_in[i] = q_shift[i];
            end
         end else if (push && off < QueueCntW'(n_new)) begin
            q_in[i] = lane[off[1:0]];
         end
      end
      count_in = base + (push ? QueueCntW'(n_new) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff  <= 2'd0;
         term_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            pcnt_ff <= pcnt_in;
            term_ff <= term_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_ff <= pend_in;
      end
      q_ff <= q_in;
   end

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("output queue overflow");

   a_window_lead: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff != 2'd0) |-> (seq_len(pend_ff[0]) > {1'b0, pcnt_ff}))
      else $error("window does not hold an unfinished sequence");

   a_term_empty: assert property (@(posedge clock) disable iff (reset)
      term_ff |-> (pcnt_ff == 2'd0))
      else $error("window busy after terminator");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (push && eot) |=> (pcnt_ff == 2'd0 && !term_ff))
      else $error("state not cleared at end of buffer");

endmodule
